@@ design/rau_pkg.sv @@
package rau_pkg;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic twos;
    logic gcd;
    logic div_start;
    logic div_sel_den;
    logic div_step;
    logic store_num;
    logic store_den;
    logic out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic early_err;
    logic ga_zero;
    logic both_even;
    logic div_last;
  } rau_stat_t;

endpackage

@@ design/rau_ctrl.sv @@
module rau_ctrl
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  rau_stat_t stat,
  output rau_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MUL  = 11'b000_0000_0010,
    S_SUM  = 11'b000_0000_0100,
    S_TWOS = 11'b000_0000_1000,
    S_GCD  = 11'b000_0001_0000,
    S_LDN  = 11'b000_0010_0000,
    S_DIVN = 11'b000_0100_0000,
    S_LDD  = 11'b000_1000_0000,
    S_DIVD = 11'b001_0000_0000,
    S_FIN  = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = stat.early_err ? S_OUT : S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        state_next = S_TWOS;
      end
      S_TWOS: begin
        if (stat.ga_zero) begin
          state_next = S_OUT;
        end else if (stat.both_even) begin
          cmd.twos = 1'b1;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.ga_zero) begin
          state_next = S_LDN;
        end else begin
          cmd.gcd = 1'b1;
        end
      end
      S_LDN: begin
        cmd.div_start = 1'b1;
        state_next = S_DIVN;
      end
      S_DIVN: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_LDD;
      end
      S_LDD: begin
        cmd.store_num = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel_den = 1'b1;
        state_next = S_DIVD;
      end
      S_DIVD: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.store_den = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ design/rau_dp.sv @@
module rau_dp
  import rau_pkg::*;
#(
  parameter int WORD_WIDTH = 32
) (
  input  logic        clk,
  input  rau_cmd_t    cmd,
  output rau_stat_t   stat,
  input  logic [1:0]  kind,
  input  logic [31:0] left_num,
  input  logic [31:0] left_den,
  input  logic [31:0] right_num,
  input  logic [31:0] right_den,
  output logic [31:0] result_num,
  output logic [30:0] result_den,
  output logic [1:0]  status
);

  localparam int W  = WORD_WIDTH;
  localparam int MW = 2 * W;
  localparam int PW = 2 * W + 1;
  localparam int KW = $clog2(PW + 1);
  localparam int CW = $clog2(PW);
  localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);

  logic [W-1:0]  n1, d1, n2, d2;
  logic          s1, s2;
  logic [1:0]    kind_r;
  logic [MW-1:0] pa, pb, pd;
  logic [PW-1:0] mag_r, den_r, ga, gb, qnum, qden;
  logic          neg;
  logic [KW-1:0] k;
  logic [PW-1:0] dvd, dvs;
  logic [PW:0]   rem;
  logic [CW-1:0] cnt;

  logic          zden, dzero;
  logic [W-1:0]  ln, ld, rn, rd;
  logic          lns, lds, rns, rds;
  logic [PW-1:0] ea, eb, sum_mag;
  logic          sum_neg, sb;
  logic [PW:0]   rem_s;
  logic          q_bit;
  logic [1:0]    st;
  logic [W-1:0]  rnum;

  assign zden  = (d1 == '0) || (d2 == '0);
  assign dzero = (kind_r == KIND_DIV) && (n2 == '0);

  assign stat.early_err = zden || dzero;
  assign stat.ga_zero   = (ga == '0);
  assign stat.both_even = !ga[0] && !gb[0];
  assign stat.div_last  = (cnt == CW'(PW - 1));

  assign lns = left_num[W-1];
  assign lds = left_den[W-1];
  assign rns = right_num[W-1];
  assign rds = right_den[W-1];
  assign ln  = lns ? -left_num[W-1:0]  : left_num[W-1:0];
  assign ld  = lds ? -left_den[W-1:0]  : left_den[W-1:0];
  assign rn  = rns ? -right_num[W-1:0] : right_num[W-1:0];
  assign rd  = rds ? -right_den[W-1:0] : right_den[W-1:0];

  assign ea = PW'(pa);
  assign eb = PW'(pb);
  assign sb = (kind_r == KIND_SUB) ? !s2 : s2;

  always_comb begin
    if (kind_r == KIND_MUL || kind_r == KIND_DIV) begin
      sum_mag = ea;
      sum_neg = s1 ^ s2;
    end else if (s1 == sb) begin
      sum_mag = ea + eb;
      sum_neg = s1;
    end else if (ea >= eb) begin
      sum_mag = ea - eb;
      sum_neg = s1;
    end else begin
      sum_mag = eb - ea;
      sum_neg = sb;
    end
  end

  assign rem_s = {rem[PW-1:0], dvd[PW-1]};
  assign q_bit = (rem_s >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n1 <= ln;
      d1 <= ld;
      n2 <= rn;
      d2 <= rd;
      s1 <= lns ^ lds;
      s2 <= rns ^ rds;
      kind_r <= kind;
    end
    if (cmd.mul) begin
      pa <= MW'(n1) * MW'((kind_r == KIND_MUL) ? n2 : d2);
      pb <= MW'(n2) * MW'(d1);
      pd <= MW'(d1) * MW'((kind_r == KIND_DIV) ? n2 : d2);
    end
    if (cmd.sum) begin
      mag_r <= sum_mag;
      den_r <= PW'(pd);
      ga <= sum_mag;
      gb <= PW'(pd);
      neg <= sum_neg;
      k <= '0;
      qnum <= '0;
      qden <= PW'(1);
    end
    if (cmd.twos) begin
      ga <= ga >> 1;
      gb <= gb >> 1;
      k <= k + KW'(1);
    end
    if (cmd.gcd) begin
      if (!ga[0]) ga <= ga >> 1;
      else if (!gb[0]) gb <= gb >> 1;
      else if (ga >= gb) ga <= ga - gb;
      else gb <= gb - ga;
    end
    if (cmd.div_start) begin
      dvd <= cmd.div_sel_den ? den_r : mag_r;
      rem <= '0;
      cnt <= '0;
      if (!cmd.div_sel_den) dvs <= gb << k;
    end
    if (cmd.div_step) begin
      rem <= q_bit ? (rem_s - {1'b0, dvs}) : rem_s;
      dvd <= {dvd[PW-2:0], q_bit};
      cnt <= cnt + CW'(1);
    end
    if (cmd.store_num) qnum <= dvd;
    if (cmd.store_den) qden <= dvd;
    if (cmd.out_load) begin
      status <= st;
      result_num <= (st == ST_OK) ? 32'($signed(rnum)) : '0;
      result_den <= (st == ST_OK) ? 31'(qden[W-2:0]) : '0;
    end
  end

  assign rnum = neg ? -qnum[W-1:0] : qnum[W-1:0];

  always_comb begin
    if (zden) st = ST_ZERO_DEN;
    else if (dzero) st = ST_DIV_ZERO;
    else if (qden >= HALF) st = ST_OVERFLOW;
    else if (neg ? (qnum > HALF) : (qnum >= HALF)) st = ST_OVERFLOW;
    else st = ST_OK;
  end

endmodule

@@ design/rational_arith_unit_top.sv @@
// Rational arithmetic unit: add, subtract, multiply or divide two fractions
// and return the result reduced by the gcd with a positive denominator.
// Input channel: in_valid/in_ready carry kind and the four operands.
// Output channel: out_valid/out_ready carry result_num, result_den, status.
// One item is worked at a time; in_ready is high only while idle.
// Flow: zero-denominator or divide-by-zero beats go from the multiply step
// straight to the output register. Otherwise the unit forms the products and
// the sum, strips the common factors of two, runs the binary gcd, and then
// divides the numerator and then the denominator by the gcd with bit-serial
// restoring division. A zero result skips the gcd and the divisions.
// The result sits in an output register; the next beat is taken while it
// waits. If the receiver stalls, a finished result holds in the datapath
// until the output register frees. Reset returns control to idle and
// drops out_valid.
module rational_arith_unit_top
  import rau_pkg::*;
#(
  parameter int WORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] left_num,
  input  logic [31:0] left_den,
  input  logic [31:0] right_num,
  input  logic [31:0] right_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_num,
  output logic [30:0] result_den,
  output logic [1:0]  status
);

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rau_dp #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .stat       (stat),
    .kind       (kind),
    .left_num   (left_num),
    .left_den   (left_den),
    .right_num  (right_num),
    .right_den  (right_den),
    .result_num (result_num),
    .result_den (result_den),
    .status     (status)
  );

endmodule

@@ tb/rational_arith_unit_top_tb.sv @@
`timescale 1ns / 100ps

module rational_arith_unit_top_tb;
  import rau_pkg::*;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  st;
  } frac_result_t;

  localparam longint unsigned HALF = 64'd1 << 31;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = KIND_ADD;
  logic [31:0] left_num = '0;
  logic [31:0] left_den = 32'd1;
  logic [31:0] right_num = '0;
  logic [31:0] right_den = 32'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_num;
  logic [30:0] result_den;
  logic [1:0]  status;

  frac_result_t expected_q[$];
  int           mismatches = 0;
  int           hold_cycles = 0;
  int           recv_mode = 0;

  rational_arith_unit_top #(.WORD_WIDTH(32)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .left_num(left_num), .left_den(left_den),
    .right_num(right_num), .right_den(right_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_num(result_num), .result_den(result_den), .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint unsigned magnitude(logic [31:0] v);
    logic [31:0] t;
    t = v[31] ? (~v + 32'd1) : v;
    return {32'd0, t};
  endfunction

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic frac_result_t reduce_fraction(logic [1:0] k, logic [31:0] ln,
                                                   logic [31:0] ld, logic [31:0] rn,
                                                   logic [31:0] rd);
    frac_result_t r;
    longint unsigned n1, d1, n2, d2, a, b, mag, den, g;
    logic s1, s2, sb, neg;
    r = '0;
    n1 = magnitude(ln);
    d1 = magnitude(ld);
    n2 = magnitude(rn);
    d2 = magnitude(rd);
    s1 = ln[31] ^ ld[31];
    s2 = rn[31] ^ rd[31];
    if (d1 == 0 || d2 == 0) begin
      r.st = ST_ZERO_DEN;
      return r;
    end
    case (k)
      KIND_ADD, KIND_SUB: begin
        a = n1 * d2;
        b = n2 * d1;
        sb = (k == KIND_SUB) ? !s2 : s2;
        if (s1 == sb) begin
          mag = a + b;
          neg = s1;
        end else if (a >= b) begin
          mag = a - b;
          neg = s1;
        end else begin
          mag = b - a;
          neg = sb;
        end
        den = d1 * d2;
      end
      KIND_MUL: begin
        mag = n1 * n2;
        den = d1 * d2;
        neg = s1 ^ s2;
      end
      default: begin
        if (n2 == 0) begin
          r.st = ST_DIV_ZERO;
          return r;
        end
        mag = n1 * d2;
        den = d1 * n2;
        neg = s1 ^ s2;
      end
    endcase
    if (mag == 0) begin
      den = 1;
      neg = 1'b0;
    end else begin
      g = gcd64(mag, den);
      mag = mag / g;
      den = den / g;
    end
    if (den > HALF - 1 || (neg ? (mag > HALF) : (mag > HALF - 1))) begin
      r.st = ST_OVERFLOW;
      return r;
    end
    r.num = neg ? (~mag[31:0] + 32'd1) : mag[31:0];
    r.den = den[30:0];
    r.st = ST_OK;
    return r;
  endfunction

  // caller is at a falling edge; returns at the falling edge after the beat
  task automatic send_beat(logic [1:0] k, logic [31:0] ln, logic [31:0] ld,
                           logic [31:0] rn, logic [31:0] rd);
    kind = k;
    left_num = ln;
    left_den = ld;
    right_num = rn;
    right_den = rd;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(reduce_fraction(k, ln, ld, rn, rd));
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_operand(logic is_den);
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return is_den ? 32'd0 : 32'hffff_ffff;
      3, 4: return $urandom;
      5: return $urandom >> $urandom_range(0, 31);
      6: return -($urandom >> $urandom_range(0, 31));
      default: return 32'($urandom_range(0, 120)) - 32'd60;
    endcase
  endfunction

  task automatic send_random(int count, logic bursty);
    int left, burst;
    logic [31:0] ld, rd;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && left > 0) begin
        ld = rand_operand(1'b1);
        rd = rand_operand(1'b1);
        if (ld == 0 && $urandom_range(0, 3) != 0) ld = 32'd1;
        if (rd == 0 && $urandom_range(0, 3) != 0) rd = 32'd7;
        send_beat(2'($urandom), rand_operand(1'b0), ld, rand_operand(1'b0), rd);
        burst--;
        left--;
      end
      if (bursty) idle_gap($urandom_range(0, 40));
    end
    idle_gap(1);
  endtask

  task automatic test_directed();
    send_beat(KIND_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_beat(KIND_DIV, 32'd1, 32'd1, 32'd3, 32'd0);
    send_beat(KIND_DIV, 32'd1, 32'd0, 32'd0, 32'd1);
    send_beat(KIND_DIV, 32'd5, 32'd3, 32'd0, 32'hffff_fff9);
    send_beat(KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_beat(KIND_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_beat(KIND_SUB, 32'd1, 32'd3, 32'd1, 32'd2);
    send_beat(KIND_MUL, 32'hffff_fffe, 32'd4, 32'd3, 32'hffff_fffa);
    send_beat(KIND_DIV, 32'd6, 32'hffff_fff7, 32'hfffffffc, 32'd3);
    send_beat(KIND_MUL, 32'd0, 32'hffff_fffd, 32'd9, 32'd2);
    send_beat(KIND_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
    send_beat(KIND_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_beat(KIND_ADD, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
    send_beat(KIND_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
    send_beat(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_beat(KIND_DIV, 32'd1, 32'h8000_0000, 32'd1, 32'd1);
    send_beat(KIND_DIV, 32'd1, 32'hffff_ffff, 32'h8000_0000, 32'd1);
    send_beat(KIND_MUL, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_fffe, 32'h7fff_ffff);
    send_beat(KIND_ADD, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
    send_beat(KIND_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(KIND_MUL, 32'h0001_0000, 32'd1, 32'h0001_0000, 32'd1);
    send_beat(KIND_ADD, 32'h0000_8000, 32'h0000_0001, 32'h0000_8000, 32'h0000_0001);
    idle_gap(1);
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    send_random(12, 1'b0);
  endtask

  task automatic test_drain_pause();
    send_random(10, 1'b1);
    wait (expected_q.size() == 0);
    @(negedge clk);
    send_random(10, 1'b0);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) recv_mode <= $urandom_range(0, 2);
      case (recv_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    frac_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat num=%h den=%h st=%0d",
                                       result_num, result_den, status);
      end else begin
        exp_r = expected_q.pop_front();
        if (result_num !== exp_r.num || result_den !== exp_r.den || status !== exp_r.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp num=%h den=%h st=%0d got num=%h den=%h st=%0d",
                     exp_r.num, exp_r.den, exp_r.st, result_num, result_den, status);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_drain_pause();
    send_random(1500, 1'b1);
    wait (expected_q.size() == 0);
    repeat (800) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/rau_pkg.sv
design/rau_ctrl.sv
design/rau_dp.sv
design/rational_arith_unit_top.sv
tb/rational_arith_unit_top_tb.sv
